// ----- hw/rtl/linear_interp_resampler_top_assert.svh -----
// Assertion macros for the resampler top level.
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LIR_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lir: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define LIR_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lir: next-cycle check failed");

`endif

// ----- hw/rtl/lir_pkg.sv -----
package lir_pkg;

   // Configuration registers are a fixed 24 bits wide.
   localparam int RegBits = 24;

   localparam int DefSampleBits  = 16;
   localparam int DefFracBits    = 16;
   localparam int DefMaxUpsample = 32;

   // Depth of the item queue between front and back.
   localparam int QueueDepth = 2;

   typedef enum logic [0:0] {
      CSR_STEP_RATIO   = 1'b0,
      CSR_OUTPUT_COUNT = 1'b1
   } csr_index_type;

   // Control that travels with a result through the multiply stage.
   typedef struct packed {
      logic valid;
      logic run_last;
      logic stream_done;
   } stage_ctrl_type;

endpackage

// ----- hw/rtl/lir_front.sv -----
module lir_front #(
   parameter int SAMPLE_BITS = lir_pkg::DefSampleBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                   req_stream_end,
   output logic                   q_valid,
   output logic [SAMPLE_BITS-1:0] q_sample,
   output logic                   q_end,
   input  logic                   q_pop
);

   localparam int PtrBits = (lir_pkg::QueueDepth > 1) ? $clog2(lir_pkg::QueueDepth) : 1;
   localparam int CntBits = $clog2(lir_pkg::QueueDepth + 1);

   logic [SAMPLE_BITS-1:0] sample_ff [lir_pkg::QueueDepth];
   logic                   end_ff    [lir_pkg::QueueDepth];
   logic [PtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]     count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign req_ready = (count_ff != CntBits'(lir_pkg::QueueDepth));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_sample  = sample_ff[rd_ptr_ff];
   assign q_end     = end_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(lir_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(lir_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         sample_ff[wr_ptr_ff] <= req_sample_in;
         end_ff[wr_ptr_ff]    <= req_stream_end;
      end
   end

endmodule

// ----- hw/rtl/lir_engine.sv -----
module lir_engine #(
   parameter int SAMPLE_BITS  = lir_pkg::DefSampleBits,
   parameter int FRAC_BITS    = lir_pkg::DefFracBits,
   parameter int MAX_UPSAMPLE = lir_pkg::DefMaxUpsample
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [lir_pkg::RegBits-1:0]          step_ratio,
   input  logic [lir_pkg::RegBits-1:0]          output_count,
   input  logic                                 q_valid,
   input  logic [SAMPLE_BITS-1:0]               q_sample,
   input  logic                                 q_end,
   output logic                                 q_pop,
   input  logic                                 out_ready,
   output lir_pkg::stage_ctrl_type              s1_ctrl,
   output logic signed [SAMPLE_BITS+FRAC_BITS+1:0] s1_prod,
   output logic [SAMPLE_BITS-1:0]               s1_base
);

   localparam int RegBits  = lir_pkg::RegBits;
   localparam int PosBits  = RegBits + FRAC_BITS;
   localparam int CntBits  = $clog2(MAX_UPSAMPLE + 1);
   localparam int ProdBits = SAMPLE_BITS + FRAC_BITS + 2;

   logic [SAMPLE_BITS-1:0]     prev_ff, prev_in;
   logic                       have_prev_ff, have_prev_in;
   logic [RegBits-1:0]         idx_ff, idx_in;
   logic [PosBits-1:0]         pos_ff, pos_in;
   logic [RegBits-1:0]         emitted_ff, emitted_in;
   logic [CntBits-1:0]         n_ff, n_in;

   lir_pkg::stage_ctrl_type    ctrl_ff, ctrl_in;
   logic signed [ProdBits-1:0] prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0]     base_ff, base_in;

   logic                       can_issue;
   logic                       room, below, interp_ok, end_ok, want;
   logic                       next_room, next_below, next_interp, next_end;
   logic                       run_last, done, emit, finish;
   logic [RegBits:0]           emitted_inc;
   logic [PosBits:0]           pos_sum;
   logic [PosBits-1:0]         pos_next;
   logic signed [SAMPLE_BITS:0] diff;
   logic signed [FRAC_BITS:0]  frac;

   assign can_issue = !ctrl_ff.valid || out_ready;

   assign room      = (n_ff < CntBits'(MAX_UPSAMPLE));
   assign below     = (emitted_ff < output_count);
   assign interp_ok = have_prev_ff && room && below && (pos_ff[PosBits-1:FRAC_BITS] < idx_ff);
   assign end_ok    = q_end && room && below;
   assign want      = interp_ok || end_ok;

   // Look one result ahead so the last result of the item is flagged.
   assign emitted_inc = {1'b0, emitted_ff} + 1'b1;
   assign pos_sum     = {1'b0, pos_ff} + PosBits'(step_ratio);
   assign pos_next    = pos_sum[PosBits] ? '1 : pos_sum[PosBits-1:0];
   assign next_room   = (n_ff < CntBits'(MAX_UPSAMPLE - 1));
   assign next_below  = (emitted_inc < {1'b0, output_count});
   assign next_interp = interp_ok && next_room && next_below &&
                        (pos_next[PosBits-1:FRAC_BITS] < idx_ff);
   assign next_end    = q_end && next_room && next_below;
   assign run_last    = !(next_interp || next_end);
   assign done        = (emitted_inc == {1'b0, output_count}) || (q_end && run_last);

   assign emit   = q_valid && want && can_issue;
   assign finish = q_valid && (!want || (emit && run_last));
   assign q_pop  = finish;

   assign diff = $signed({q_sample[SAMPLE_BITS-1], q_sample}) -
                 $signed({prev_ff[SAMPLE_BITS-1], prev_ff});
   assign frac = $signed({1'b0, pos_ff[FRAC_BITS-1:0]});

   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      emitted_in   = emitted_ff;
      n_in         = n_ff;
      ctrl_in      = ctrl_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;

      if (can_issue) begin
         ctrl_in.valid = 1'b0;
      end

      if (emit) begin
         ctrl_in.valid       = 1'b1;
         ctrl_in.run_last    = run_last;
         ctrl_in.stream_done = done;
         n_in                = n_ff + 1'b1;
         emitted_in          = emitted_inc[RegBits-1:0];
         if (interp_ok) begin
            prod_in = ProdBits'(diff * frac);
            base_in = prev_ff;
            pos_in  = pos_next;
         end else begin
            // End clamp: repeat the last sample.
            prod_in = '0;
            base_in = q_sample;
         end
      end

      if (finish) begin
         n_in = '0;
         if (q_end) begin
            prev_in      = '0;
            have_prev_in = 1'b0;
            idx_in       = '0;
            pos_in       = '0;
            emitted_in   = '0;
         end else begin
            prev_in      = q_sample;
            have_prev_in = 1'b1;
            if (idx_ff != '1) begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         emitted_ff   <= '0;
         n_ff         <= '0;
         ctrl_ff      <= '0;
      end else begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         emitted_ff   <= emitted_in;
         n_ff         <= n_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
   end

   assign s1_ctrl = ctrl_ff;
   assign s1_prod = prod_ff;
   assign s1_base = base_ff;

endmodule

// ----- hw/rtl/lir_out.sv -----
module lir_out #(
   parameter int SAMPLE_BITS = lir_pkg::DefSampleBits,
   parameter int FRAC_BITS   = lir_pkg::DefFracBits
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lir_pkg::stage_ctrl_type                 s1_ctrl,
   input  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] s1_prod,
   input  logic [SAMPLE_BITS-1:0]                  s1_base,
   output logic                                    out_ready,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [SAMPLE_BITS-1:0]                  rsp_sample_out,
   output logic                                    rsp_run_last,
   output logic                                    rsp_stream_done
);

   localparam int ProdBits = SAMPLE_BITS + FRAC_BITS + 2;

   logic                       valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0]     sample_ff;
   logic                       run_last_ff;
   logic                       done_ff;
   logic signed [ProdBits-1:0] step;
   logic                       load;

   // Floor division by the fraction scale is an arithmetic shift.
   assign step      = s1_prod >>> FRAC_BITS;
   assign out_ready = !valid_ff || rsp_ready;
   assign load      = s1_ctrl.valid && out_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff   <= s1_base + step[SAMPLE_BITS-1:0];
         run_last_ff <= s1_ctrl.run_last;
         done_ff     <= s1_ctrl.stream_done;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_sample_out  = sample_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_stream_done = done_ff;

endmodule

// ----- hw/rtl/linear_interp_resampler_top.sv -----
// Linear interpolation resampler. Output i of a stream sits at source position
// i*step_ratio (unsigned Q8.16) and is prev + floor((cur - prev) * frac), made
// from the two input samples around it; an input item releases every pending
// output up to its position, at most MAX_UPSAMPLE of them, and the item marked
// stream_end pads up to output_count with its own sample, then clears the
// stream state. The back end issues one result per cycle from its single
// interpolation issue slot while the output side can take it; an item that
// causes no result is still taken from the queue. An issued result passes the
// product register and then the output register. A two-entry queue lets new
// items in while the back end works. Write step_ratio and output_count only
// while the block is idle.

`include "linear_interp_resampler_top_assert.svh"

module linear_interp_resampler_top #(
   parameter int SAMPLE_BITS  = lir_pkg::DefSampleBits,
   parameter int FRAC_BITS    = lir_pkg::DefFracBits,
   parameter int MAX_UPSAMPLE = lir_pkg::DefMaxUpsample
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [SAMPLE_BITS-1:0]      req_sample_in,
   input  logic                        req_stream_end,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                        rsp_run_last,
   output logic                        rsp_stream_done,
   // Configuration write port
   input  logic                        csr_write,
   input  logic [0:0]                  csr_index,
   input  logic [lir_pkg::RegBits-1:0] csr_wdata
);

   localparam int RegBits  = lir_pkg::RegBits;
   localparam int ProdBits = SAMPLE_BITS + FRAC_BITS + 2;
   // Unity ratio: one input sample per output sample.
   localparam logic [RegBits-1:0] UnityRatio = RegBits'(64'd1 << FRAC_BITS);

   logic [RegBits-1:0]         step_ratio_ff, step_ratio_in;
   logic [RegBits-1:0]         output_count_ff, output_count_in;

   logic                       q_valid;
   logic [SAMPLE_BITS-1:0]     q_sample;
   logic                       q_end;
   logic                       q_pop;
   logic                       out_ready;
   lir_pkg::stage_ctrl_type    s1_ctrl;
   logic signed [ProdBits-1:0] s1_prod;
   logic [SAMPLE_BITS-1:0]     s1_base;

   // Configuration registers: take the write data at once, no read-back.
   always_comb begin
      step_ratio_in   = step_ratio_ff;
      output_count_in = output_count_ff;
      if (csr_write) begin
         unique case (lir_pkg::csr_index_type'(csr_index))
            lir_pkg::CSR_STEP_RATIO:   step_ratio_in   = csr_wdata;
            lir_pkg::CSR_OUTPUT_COUNT: output_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff   <= UnityRatio;
         output_count_ff <= '0;
      end else begin
         step_ratio_ff   <= step_ratio_in;
         output_count_ff <= output_count_in;
      end
   end

   // Front: accept items into the queue.
   lir_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_stream_end (req_stream_end),
      .q_valid        (q_valid),
      .q_sample       (q_sample),
      .q_end          (q_end),
      .q_pop          (q_pop)
   );

   // Back: walk the output positions of the head item, one result per cycle while
   // the output side is ready, and form the interpolation product.
   lir_engine #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRAC_BITS    (FRAC_BITS),
      .MAX_UPSAMPLE (MAX_UPSAMPLE)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_ratio   (step_ratio_ff),
      .output_count (output_count_ff),
      .q_valid      (q_valid),
      .q_sample     (q_sample),
      .q_end        (q_end),
      .q_pop        (q_pop),
      .out_ready    (out_ready),
      .s1_ctrl      (s1_ctrl),
      .s1_prod      (s1_prod),
      .s1_base      (s1_base)
   );

   // Back: scale, add and hold the result until it is taken.
   lir_out #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_out (
      .clock           (clock),
      .reset           (reset),
      .s1_ctrl         (s1_ctrl),
      .s1_prod         (s1_prod),
      .s1_base         (s1_base),
      .out_ready       (out_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

   // The end of a stream is always the last result of its item.
   `LIR_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid && rsp_stream_done, rsp_run_last)
   // Drop an item from the queue only when one is there.
   `LIR_ASSERT_IMPLY(a_pop_has_item, clock, reset, q_pop, q_valid)
   // Hold a stalled product stage.
   `LIR_ASSERT_NEXT(a_stage_holds, clock, reset, s1_ctrl.valid && !out_ready, s1_ctrl.valid)

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

   import lir_pkg::*;

   localparam int SampleBits   = DefSampleBits;
   localparam int FracBits     = DefFracBits;
   localparam int MaxPerItem   = DefMaxUpsample;
   localparam int PosBits      = RegBits + FracBits;
   localparam logic [PosBits-1:0] PosMax = '1;
   localparam logic [RegBits-1:0] RegMax = '1;
   localparam logic [RegBits-1:0] Unity  = RegBits'(1) << FracBits;
   // Cycles to let a queued item that releases nothing drain before a write.
   localparam int SettleCycles = 16;
   localparam int CycleLimit   = 600000;
   localparam int RandomItems  = 225;

   // One output sample as the result channel presents it.
   typedef struct packed {
      logic [SampleBits-1:0] sample;
      logic                  run_last;
      logic                  stream_done;
   } resampled_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SampleBits-1:0] req_sample_in = '0;
   logic                  req_stream_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SampleBits-1:0] rsp_sample_out;
   logic                  rsp_run_last;
   logic                  rsp_stream_done;
   logic                  csr_write = 1'b0;
   csr_index_type         csr_index = CSR_STEP_RATIO;
   logic [RegBits-1:0]    csr_wdata = '0;

   // Register copies, as last written to the block.
   logic [RegBits-1:0]    cfg_ratio = Unity;
   logic [RegBits-1:0]    cfg_count = '0;

   // Stream state of the predictor; clears on every end item.
   logic signed [SampleBits-1:0] prev_sample = '0;
   logic                         have_prev = 1'b0;
   logic [RegBits-1:0]           in_index = '0;
   logic [PosBits-1:0]           out_pos = '0;
   logic [RegBits-1:0]           emitted = '0;

   // Output samples predicted but not yet seen on the result channel, oldest first.
   resampled_type pending_outputs[$];

   int  errors = 0;
   int  cycle_count = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  streams_sent = 0;
   int  settings_used = 0;
   int  hold_request = 0;
   int  holds_done = 0;
   // When low, both sides run with no random gaps or stalls; a requested hold-off still applies.
   bit  idle_enable = 1'b1;

   linear_interp_resampler_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Count cycles and kill a hung run.
   initial begin
      while (cycle_count < CycleLimit) @(posedge clock) cycle_count++;
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, pending_outputs.size());
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("cycle %0d: %s: got %0h, want %0h", cycle_count, what, got, want);
   endtask

   // Append one predicted output at the tail of the queue.
   task automatic enqueue_output(input resampled_type r);
      pending_outputs.insert(pending_outputs.size(), r);
   endtask

   // Advance the predictor by one accepted item and queue the outputs it releases.
   // Interpolation is prev + floor((cur - prev) * frac / 2^16); an arithmetic
   // shift of the signed product gives the floor for both signs.
   task automatic predict_resampled(input logic [SampleBits-1:0] value, input logic last);
      logic signed [SampleBits-1:0] cur;
      longint                       prod;
      logic [SampleBits-1:0]        interp;
      resampled_type                r;
      int                           n;
      cur = value;
      n = 0;
      if (have_prev) begin
         // Release every pending output up to the previous input, lagging ones too.
         while (n < MaxPerItem && emitted < cfg_count &&
                out_pos[PosBits-1:FracBits] <= in_index - RegBits'(1)) begin
            prod = (longint'(cur) - longint'(prev_sample)) * longint'(out_pos[FracBits-1:0]);
            interp = SampleBits'(longint'(prev_sample) + (prod >>> FracBits));
            emitted++;
            enqueue_output('{interp, 1'b0, emitted == cfg_count});
            n++;
            // Saturate the position instead of wrapping.
            if (PosMax - out_pos < PosBits'(cfg_ratio))
               out_pos = PosMax;
            else
               out_pos = out_pos + PosBits'(cfg_ratio);
         end
      end
      if (last) begin
         // Pad the owed outputs with the last sample, still under the cap.
         while (n < MaxPerItem && emitted < cfg_count) begin
            emitted++;
            enqueue_output('{cur, 1'b0, emitted == cfg_count});
            n++;
         end
         prev_sample = '0;
         have_prev = 1'b0;
         in_index = '0;
         out_pos = '0;
         emitted = '0;
      end else begin
         prev_sample = cur;
         have_prev = 1'b1;
         if (in_index != RegMax) in_index++;
      end
      // Tag the final output of this item, and of the stream on an end item.
      if (n > 0) begin
         r = pending_outputs[pending_outputs.size() - 1];
         r.run_last = 1'b1;
         if (last) r.stream_done = 1'b1;
         pending_outputs[pending_outputs.size() - 1] = r;
      end
   endtask

   // Offer one item after a random gap and hold it until the block takes it.
   // Valid stays high into the next item when that one draws no gap.
   task automatic send_sample(input logic [SampleBits-1:0] value, input logic last);
      int gap;
      gap = idle_enable ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      req_stream_end <= last;
      do @(posedge clock); while (!req_ready);
      predict_resampled(value, last);
      items_sent++;
      if (last) streams_sent++;
   endtask

   // Drop valid, wait for every owed output, then let trailing items drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [RegBits-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_STEP_RATIO)
         cfg_ratio = value;
      else
         cfg_count = value;
      settings_used++;
   endtask

   task automatic set_stream_params(input logic [RegBits-1:0] ratio,
                                    input logic [RegBits-1:0] count);
      wait_idle();
      write_register(CSR_STEP_RATIO, ratio);
      write_register(CSR_OUTPUT_COUNT, count);
   endtask

   // Unity step with full-scale samples; the end item pads with its own sample.
   task automatic test_unity_extremes();
      set_stream_params(Unity, 24'd6);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hffff, 1'b0);
      send_sample(16'h0001, 1'b1);
   endtask

   // Half steps hit frac = 0.5 with falling and rising slopes (floor on negatives).
   task automatic test_half_step();
      set_stream_params(Unity >> 1, 24'd7);
      send_sample(16'd1000, 1'b0);
      send_sample(-16'sd1001, 1'b0);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h8000, 1'b1);
   endtask

   // A lone end item with no previous sample: all outputs are the end clamp.
   task automatic test_single_item_stream();
      set_stream_params(Unity, 24'd4);
      send_sample(16'h1234, 1'b1);
   endtask

   // No outputs at all; the end item only clears the stream.
   task automatic test_zero_count();
      set_stream_params(Unity, 24'd0);
      send_sample(16'h4000, 1'b0);
      send_sample(16'hc000, 1'b0);
      send_sample(16'h0042, 1'b1);
   endtask

   // Output count reached early: later items and the end item release nothing.
   task automatic test_count_reached();
      set_stream_params(Unity, 24'd2);
      send_sample(16'h0100, 1'b0);
      send_sample(16'h0200, 1'b0);
      send_sample(16'h0300, 1'b0);
      send_sample(16'h0400, 1'b1);
   endtask

   // 32x upsampling hits the cap exactly; a zero step keeps every output lagging,
   // and the maximum count leaves outputs to be dropped at the end.
   task automatic test_result_cap();
      set_stream_params(24'd2048, RegMax);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h1111, 1'b1);
      set_stream_params(24'd0, 24'd70);
      send_sample(16'h0fff, 1'b0);
      send_sample(16'hf001, 1'b0);
      send_sample(16'h5555, 1'b1);
   endtask

   // Change the step between items of one stream, at the largest and a tiny value.
   task automatic test_ratio_change();
      set_stream_params(Unity, 24'd40);
      send_sample(16'h2000, 1'b0);
      send_sample(16'he000, 1'b0);
      wait_idle();
      write_register(CSR_STEP_RATIO, RegMax);
      send_sample(16'h3000, 1'b0);
      send_sample(16'h9000, 1'b0);
      wait_idle();
      write_register(CSR_STEP_RATIO, 24'd1000);
      send_sample(16'h0abc, 1'b0);
      send_sample(16'h7654, 1'b1);
   endtask

   // Hold the result side off while items keep coming, so the input stalls.
   task automatic test_backpressure();
      set_stream_params(Unity >> 2, 24'd200);
      idle_enable = 1'b0;
      hold_request = 150;
      for (int i = 0; i < 20; i++) send_sample(16'($urandom()), i == 19);
      idle_enable = 1'b1;
   endtask

   // Random streams: random step and count per stream, some mid-stream step changes.
   task automatic test_random_streams();
      logic [RegBits-1:0]    ratio;
      logic [RegBits-1:0]    count;
      logic [SampleBits-1:0] value;
      int                    length;
      int                    goal;
      goal = items_sent + RandomItems;
      while (items_sent < goal) begin
         case ($urandom_range(0, 9))
            0:       ratio = RegBits'($urandom_range(0, 2047));
            1:       ratio = RegBits'($urandom());
            2:       ratio = RegMax;
            default: ratio = RegBits'($urandom_range(2048, 4 * 65536));
         endcase
         case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = RegBits'($urandom());
            default: count = RegBits'($urandom_range(1, 60));
         endcase
         set_stream_params(ratio, count);
         idle_enable = ($urandom_range(0, 3) != 0);
         length = $urandom_range(1, 16);
         for (int i = 0; i < length; i++) begin
            if ($urandom_range(0, 7) == 0)
               value = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            else
               value = SampleBits'($urandom());
            // Now and then retune the step inside the stream.
            if (i > 0 && $urandom_range(0, 11) == 0) begin
               wait_idle();
               write_register(CSR_STEP_RATIO, RegBits'($urandom_range(0, 3 * 65536)));
            end
            send_sample(value, i == length - 1);
         end
      end
      idle_enable = 1'b1;
   endtask

   // Result side: stall a random number of cycles per output, or take a long
   // hold-off when one is requested, then accept the next output.
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_enable ? $urandom_range(0, 8) : 0;
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
            holds_done++;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare every accepted output with the oldest prediction, field by field.
   always @(posedge clock) begin
      resampled_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_outputs.size() == 0) begin
            report_mismatch("output with none expected", int'(rsp_sample_out), 0);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_sample_out !== want.sample)
               report_mismatch("sample_out", int'(rsp_sample_out), int'(want.sample));
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", int'(rsp_run_last), int'(want.run_last));
            if (rsp_stream_done !== want.stream_done)
               report_mismatch("stream_done", int'(rsp_stream_done),
                               int'(want.stream_done));
         end
      end
   end

   initial begin
      // Hold reset once, at the start.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_unity_extremes();
      test_half_step();
      test_single_item_stream();
      test_zero_count();
      test_count_reached();
      test_result_cap();
      test_ratio_change();
      test_backpressure();
      test_random_streams();

      // Drain: wait out every owed output plus the pipeline tail.
      wait_idle();
      if (pending_outputs.size() != 0)
         report_mismatch("outputs never delivered", 0, pending_outputs.size());

      $display("ran %0d streams of %0d items, %0d outputs checked",
               streams_sent, items_sent, results_checked);
      $display("%0d register writes, %0d long result hold-offs, %0d mismatches",
               settings_used, holds_done, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
